@@ rtl/unordered_set_table_core_macros.svh @@
// assertion helpers used by rtl/usc_ctrl.sv
// every macro samples on clk and is disabled while arst_n is low
`ifndef UNORDERED_SET_TABLE_CORE_MACROS_SVH
`define UNORDERED_SET_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define USC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("usc assertion failed");

// next-cycle implication
`define USC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usc assertion failed");

`endif

@@ rtl/usc_pkg.sv @@
`default_nettype none
package usc_pkg;

	// field widths of the command and result beats
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 6;
	localparam int CNT_W   = 7;
	localparam int ST_W    = 2;

	// command codes (code 3 behaves as a lookup)
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd3;

	// control of the cell ring from the sequencer
	typedef struct packed {
		logic               shift;
		logic [VALUE_W-1:0] tail;
	} usc_ring_t;

endpackage
`default_nettype wire

@@ rtl/usc_cmd_if.sv @@
`default_nettype none
interface usc_cmd_if import usc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/usc_res_if.sv @@
`default_nettype none
interface usc_res_if import usc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;
	logic [CNT_W-1:0] element_count;
	logic [ST_W-1:0]  status;

	modport source (output valid, output found, output position, output element_count,
		output status, input ready);
	modport sink   (input valid, input found, input position, input element_count,
		input status, output ready);
endinterface
`default_nettype wire

@@ rtl/usc_cell.sv @@
`default_nettype none
module usc_cell import usc_pkg::*; (
	input  logic               clk,
	input  logic               shift,
	input  logic [VALUE_W-1:0] din,
	output logic [VALUE_W-1:0] dout
);

	logic [VALUE_W-1:0] data_q;

	// one stored element, passed on to the neighbour while the ring turns
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

endmodule
`default_nettype wire

@@ rtl/usc_ctrl.sv @@
`default_nettype none
`include "unordered_set_table_core_macros.svh"
module usc_ctrl import usc_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	usc_cmd_if.sink            req,
	usc_res_if.source          rsp,
	input  logic [VALUE_W-1:0] head,
	output usc_ring_t          ring
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_FIX  = 4'b0100,
		S_DONE = 4'b1000
	} usc_state_t;

	usc_state_t         state_q;
	logic [IW-1:0]      step_q;
	logic [CW-1:0]      count_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [VALUE_W-1:0] value_q;
	logic               hit_q;
	logic [IW-1:0]      idx_q;
	logic [VALUE_W-1:0] last_q;

	logic               rsp_valid_q;
	logic               found_q;
	logic [POS_W-1:0]   position_q;
	logic [CNT_W-1:0]   element_count_q;
	logic [ST_W-1:0]    status_q;

	logic          accept;
	logic [CW-1:0] step_ext;
	logic          in_use;
	logic          match;
	logic          hit_nxt;
	logic [IW-1:0] idx_nxt;
	logic          is_ins;
	logic          is_del;
	logic          last_step;
	logic          ins_wr;
	logic          fix_wr;
	logic          slot_free;
	logic          res_load;
	logic [IW-1:0] pos_nxt;
	logic [ST_W-1:0] st_nxt;
	logic [CW-1:0] count_nxt;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// compare at the head cell while the ring turns
	assign step_ext  = CW'(step_q);
	assign in_use    = step_ext < count_q;
	assign match     = (state_q == S_SCAN) && in_use && (head == value_q);
	assign hit_nxt   = hit_q || match;
	assign idx_nxt   = hit_q ? idx_q : step_q;
	assign is_ins    = (cmd_q == CMD_INSERT);
	assign is_del    = (cmd_q == CMD_DELETE);
	assign last_step = (step_q == IW'(DEPTH - 1));

	// insert lands in the first free slot, delete refills the hole with the last element
	assign ins_wr = (state_q == S_SCAN) && is_ins && !hit_q && (step_ext == count_q);
	assign fix_wr = (state_q == S_FIX) && (step_q == idx_q);

	assign ring.shift = (state_q == S_SCAN) || (state_q == S_FIX);
	assign ring.tail  = ins_wr ? value_q : (fix_wr ? last_q : head);

	// result decision once the scan is over
	always_comb begin
		pos_nxt   = '0;
		st_nxt    = ST_NOT_FOUND;
		count_nxt = count_q;
		priority if (is_ins) begin
			priority if (hit_q) begin
				pos_nxt = idx_q;
				st_nxt  = ST_DUPLICATE;
			end else if (count_q == CW'(DEPTH)) begin
				st_nxt = ST_FULL;
			end else begin
				pos_nxt   = IW'(count_q);
				st_nxt    = ST_OK;
				count_nxt = count_q + CW'(1);
			end
		end else if (is_del) begin
			if (hit_q) begin
				pos_nxt   = idx_q;
				st_nxt    = ST_OK;
				count_nxt = count_q - CW'(1);
			end
		end else begin
			if (hit_q) begin
				pos_nxt = idx_q;
				st_nxt  = ST_OK;
			end
		end
	end

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign res_load  = (state_q == S_DONE) && slot_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			count_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						step_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					hit_q  <= hit_nxt;
					step_q <= step_q + IW'(1);
					if (last_step) begin
						step_q  <= '0;
						state_q <= (is_del && hit_nxt) ? S_FIX : S_DONE;
					end
				end
				S_FIX: begin
					step_q <= step_q + IW'(1);
					if (last_step) begin
						step_q  <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						count_q <= count_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command capture, match index and last element
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			value_q <= req.value;
		end
		if (match && !hit_q) begin
			idx_q <= idx_nxt;
		end
		if ((state_q == S_SCAN) && (count_q != '0) && (step_ext == count_q - CW'(1))) begin
			last_q <= head;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q         <= hit_q;
			position_q      <= POS_W'(pos_nxt);
			element_count_q <= CNT_W'(count_nxt);
			status_q        <= st_nxt;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.found         = found_q;
	assign rsp.position      = position_q;
	assign rsp.element_count = element_count_q;
	assign rsp.status        = status_q;

	// checks
	`USC_ASSERT_IMP(a_count_max, 1'b1, count_q <= CW'(DEPTH))
	`USC_ASSERT_NXT(a_count_hold, !res_load, $stable(count_q))
	`USC_ASSERT_NXT(a_accept_scan, accept, state_q == S_SCAN)
	`USC_ASSERT_IMP(a_full_only_when_full, res_load && (st_nxt == ST_FULL),
		count_q == CW'(DEPTH))
	`USC_ASSERT_IMP(a_fix_needs_hit, state_q == S_FIX, hit_q && is_del)

endmodule
`default_nettype wire

@@ rtl/unordered_set_table_core.sv @@
// channel  | modport | beat contents
// req      | sink    | cmd, value
// rsp      | source  | found, position, element_count, status
//
// a command turns the ring once in S_SCAN and ends in S_DONE; a delete that hits adds S_FIX between them
// the cells form a ring that turns one element per cycle past the compare at cell 0
// a delete that hits turns the ring a second time to drop the last element into the hole
// reset clears the element count; cell contents stay undefined until written
// a new command is taken while a result still waits; it completes once rsp takes that beat
`default_nettype none
module unordered_set_table_core import usc_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	usc_cmd_if.sink   req,
	usc_res_if.source rsp
);

	usc_ring_t          ring;
	logic [VALUE_W-1:0] cell_data [DEPTH];

	// ring of element cells, cell 0 feeds the compare and the tail cell
	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			if (i == DEPTH - 1) begin : g_tail
				usc_cell u_cell (
					.clk   (clk),
					.shift (ring.shift),
					.din   (ring.tail),
					.dout  (cell_data[i])
				);
			end else begin : g_body
				usc_cell u_cell (
					.clk   (clk),
					.shift (ring.shift),
					.din   (cell_data[i+1]),
					.dout  (cell_data[i])
				);
			end
		end
	endgenerate

	// sequencer, count and result register
	usc_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.head   (cell_data[0]),
		.ring   (ring)
	);

endmodule
`default_nettype wire
